// ===== hdl/bpem_pkg.sv =====
// Shared types and constants of the batch packet error monitor.
// Used by the controller, the datapath, the divider and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bpem_pkg;

   localparam int unsigned SEQ_WIDTH      = 32;
   localparam int unsigned RSSI_WIDTH     = 7;
   localparam int unsigned COUNT_WIDTH    = 16;
   localparam int unsigned TOTAL_WIDTH    = 24;
   localparam int unsigned RATE_WIDTH     = 17;
   localparam int unsigned AVG_WIDTH      = 15;
   localparam int unsigned PATTERN_WIDTH  = 12;
   localparam int unsigned PATTERN_COUNT  = 4096;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned QUO_WIDTH      = 16;
   localparam int unsigned DIV_STEPS      = QUO_WIDTH;
   localparam int unsigned DIV_CNT_WIDTH  = $clog2(DIV_STEPS + 1);

   localparam logic [PATTERN_WIDTH:0] PATTERN_LIMIT = (PATTERN_WIDTH + 1)'(PATTERN_COUNT);
   localparam logic [SEQ_WIDTH-1:0]   SEQ_ALL_ONES  = '1;
   localparam logic [RATE_WIDTH-1:0]  RATE_ONE      = RATE_WIDTH'(65536);
   localparam logic [RATE_WIDTH-1:0]  BEST_ERROR_RESET = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = '1;
   localparam logic [CSR_DATA_WIDTH-1:0] BATCH_SIZE_RESET = CSR_DATA_WIDTH'(100);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATCH_SIZE   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWEEP_ENABLE = 1'd1;

   typedef enum logic {
      DIV_RATE,
      DIV_AVG
   } div_sel_type;

   typedef struct packed {
      logic                  mode;
      logic [SEQ_WIDTH-1:0]  sequence_number;
      logic [RSSI_WIDTH-1:0] rssi_magnitude;
   } req_type;

   typedef struct packed {
      logic [31:0]              batch_index;
      logic [COUNT_WIDTH-1:0]   batch_received;
      logic [SEQ_WIDTH-1:0]     batch_span;
      logic [RATE_WIDTH-1:0]    error_rate;
      logic [AVG_WIDTH-1:0]     rssi_average;
      logic [PATTERN_WIDTH-1:0] pattern_used;
      logic [PATTERN_WIDTH-1:0] best_pattern;
      logic [PATTERN_WIDTH-1:0] next_pattern;
   } rsp_type;

   typedef struct packed {
      logic        latch_req;
      logic        apply_packet;
      logic        check;
      logic        silent_close;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_rate;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic close_needed;
      logic counter_zero;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/batch_packet_error_monitor_unit.sv =====
// Top level of the batch packet error monitor: joins the controller and the datapath.
// Depends on bpem_pkg, bpem_ctrl, bpem_dp and, through the datapath, bpem_div.
//
//   Channel   Direction  Ports                                    Payload
//   req       in         req_valid, req_stall, req_payload        bpem_pkg::req_type
//   rsp       out        rsp_valid, rsp_stall, rsp_payload        bpem_pkg::rsp_type
//   csr       in         csr_write_enable, csr_index, csr_write_data   16-bit write data
//
// A request that does not close a batch passes through the idle, update and check states before the next acceptance.
// A close that reports a summary runs the shared 16-step restoring divider
// once for the error rate and once for the RSSI average, then emits the summary.
// A silent close (the first one, or after the batch number wraps) returns to idle without a summary.
// Reset is synchronous; the summary register lets a new request in while a result waits,
// and a further summary waits only while the previous one is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module batch_packet_error_monitor_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire bpem_pkg::req_type                    req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output bpem_pkg::rsp_type                         rsp_payload,
   input  wire logic                                 csr_write_enable,
   input  wire logic [bpem_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bpem_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import bpem_pkg::*;

   cmd_type    cmd;
   status_type status;

   bpem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bpem_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

// ===== hdl/bpem_div.sv =====
// Restoring divider that produces a 16-bit quotient, one bit per cycle.
// Depends on bpem_pkg; the caller guarantees that the initial remainder is below the divisor.
`timescale 1ns / 1ps
`default_nettype none

module bpem_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [bpem_pkg::SEQ_WIDTH-1:0] rem_init,
   input  wire logic [bpem_pkg::SEQ_WIDTH-1:0] divisor,
   input  wire logic [bpem_pkg::QUO_WIDTH-1:0] feed_init,
   output logic                                busy,
   output logic [bpem_pkg::QUO_WIDTH-1:0]      quotient
);
   import bpem_pkg::*;

   logic [SEQ_WIDTH-1:0]     rem_ff, rem_in;
   logic [SEQ_WIDTH-1:0]     dvs_ff, dvs_in;
   logic [QUO_WIDTH-1:0]     feed_ff, feed_in;
   logic [QUO_WIDTH-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [SEQ_WIDTH:0]       trial;
   logic                     fits;

   assign trial = {rem_ff, feed_ff[QUO_WIDTH-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      feed_in = feed_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in  = rem_init;
         dvs_in  = divisor;
         feed_in = feed_init;
         quo_in  = '0;
         cnt_in  = DIV_CNT_WIDTH'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? SEQ_WIDTH'(trial - {1'b0, dvs_ff}) : trial[SEQ_WIDTH-1:0];
         feed_in = {feed_ff[QUO_WIDTH-2:0], 1'b0};
         quo_in  = {quo_ff[QUO_WIDTH-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      feed_ff <= feed_in;
      quo_ff  <= quo_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/bpem_ctrl.sv =====
// Controller state machine: sequences request intake, batch checks, divisions and summaries.
// Depends on bpem_pkg; drives the datapath through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bpem_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire bpem_pkg::status_type status,
   output bpem_pkg::cmd_type         cmd
);
   import bpem_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_CHECK,
      ST_START,
      ST_WAIT_RATE,
      ST_WAIT_AVG,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_RATE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.apply_packet = 1'b1;
            state_in         = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (!status.close_needed) begin
               state_in = ST_IDLE;
            end else if (status.counter_zero) begin
               cmd.silent_close = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_RATE;
            state_in      = ST_WAIT_RATE;
         end
         ST_WAIT_RATE: begin
            if (!status.div_busy) begin
               cmd.take_rate = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_AVG;
               state_in      = ST_WAIT_AVG;
            end
         end
         ST_WAIT_AVG: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

`default_nettype wire

// ===== hdl/bpem_dp.sv =====
// Datapath: batch counters, configuration registers, pattern sweep and the summary register.
// Depends on bpem_pkg and bpem_div; obeys commands from bpem_ctrl and reports status back.
`timescale 1ns / 1ps
`default_nettype none

module bpem_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bpem_pkg::req_type                   req_payload,
   input  wire logic                                csr_write_enable,
   input  wire logic [bpem_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bpem_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output bpem_pkg::rsp_type                        rsp_payload,
   input  wire bpem_pkg::cmd_type                   cmd,
   output bpem_pkg::status_type                     status
);
   import bpem_pkg::*;

   req_type                  req_ff, req_in;
   logic [CSR_DATA_WIDTH-1:0] bs_ff, bs_in;
   logic                     sweep_en_ff, sweep_en_in;
   logic [SEQ_WIDTH-1:0]     last_ff, last_in;
   logic [SEQ_WIDTH-1:0]     first_ff, first_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_WIDTH-1:0]   tot_ff, tot_in;
   logic [31:0]              batch_cnt_ff, batch_cnt_in;
   logic [PATTERN_WIDTH-1:0] cur_pat_ff, cur_pat_in;
   logic [PATTERN_WIDTH-1:0] sweep_idx_ff, sweep_idx_in;
   logic [PATTERN_WIDTH-1:0] best_pat_ff, best_pat_in;
   logic [RATE_WIDTH-1:0]    best_err_ff, best_err_in;
   logic [SEQ_WIDTH-1:0]     span_ff, span_in;
   logic [QUO_WIDTH-1:0]     rate_q_ff, rate_q_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     pkt_valid;
   logic                     seq_lower;
   logic [COUNT_WIDTH-1:0]   cnt_base;
   logic [TOTAL_WIDTH-1:0]   tot_base;
   logic [SEQ_WIDTH-1:0]     first_base;
   logic [SEQ_WIDTH-1:0]     span_now;
   logic                     batch_empty;
   logic                     batch_overfull;
   logic [RATE_WIDTH-1:0]    rate_val;
   logic [AVG_WIDTH-1:0]     avg_val;
   logic                     better;
   logic [PATTERN_WIDTH-1:0] idx_now;
   logic [PATTERN_WIDTH:0]   idx_next;
   logic [SEQ_WIDTH-1:0]     div_rem;
   logic [SEQ_WIDTH-1:0]     div_dvs;
   logic [QUO_WIDTH-1:0]     div_feed;
   logic                     div_busy;
   logic [QUO_WIDTH-1:0]     div_quo;

   assign pkt_valid = !req_ff.mode && req_ff.sequence_number != '0
                      && req_ff.sequence_number != SEQ_ALL_ONES;
   assign seq_lower  = req_ff.sequence_number < last_ff;
   assign cnt_base   = seq_lower ? '0 : cnt_ff;
   assign tot_base   = seq_lower ? '0 : tot_ff;
   assign first_base = seq_lower ? '0 : first_ff;
   assign span_now   = last_ff - first_ff + SEQ_WIDTH'(1);

   assign batch_empty    = cnt_ff == '0 || span_ff == '0;
   assign batch_overfull = {(SEQ_WIDTH - COUNT_WIDTH)'(0), cnt_ff} > span_ff;
   assign rate_val = batch_empty ? RATE_ONE :
                     batch_overfull ? '0 : {1'b0, rate_q_ff};
   assign avg_val  = batch_empty ? '0 : div_quo[AVG_WIDTH-1:0];

   assign better   = rate_val < best_err_ff;
   assign idx_now  = ({1'b0, sweep_idx_ff} >= PATTERN_LIMIT) ? '0 : sweep_idx_ff;
   assign idx_next = {1'b0, idx_now} + (PATTERN_WIDTH + 1)'(1);

   always_comb begin
      if (cmd.div_sel == DIV_RATE) begin
         div_rem  = span_ff - {(SEQ_WIDTH - COUNT_WIDTH)'(0), cnt_ff};
         div_dvs  = span_ff;
         div_feed = '0;
      end else begin
         div_rem  = {(SEQ_WIDTH - (TOTAL_WIDTH - 8))'(0), tot_ff[TOTAL_WIDTH-1:8]};
         div_dvs  = {(SEQ_WIDTH - COUNT_WIDTH)'(0), cnt_ff};
         div_feed = {tot_ff[7:0], 8'd0};
      end
   end

   bpem_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .rem_init  (div_rem),
      .divisor   (div_dvs),
      .feed_init (div_feed),
      .busy      (div_busy),
      .quotient  (div_quo)
   );

   always_comb begin
      req_in       = req_ff;
      bs_in        = bs_ff;
      sweep_en_in  = sweep_en_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      tot_in       = tot_ff;
      batch_cnt_in = batch_cnt_ff;
      cur_pat_in   = cur_pat_ff;
      sweep_idx_in = sweep_idx_ff;
      best_pat_in  = best_pat_ff;
      best_err_in  = best_err_ff;
      span_in      = span_ff;
      rate_q_in    = rate_q_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.latch_req) begin
         req_in = req_payload;
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_BATCH_SIZE:   bs_in       = csr_write_data;
            CSR_SWEEP_ENABLE: sweep_en_in = csr_write_data[0];
            default: ;
         endcase
      end

      if (cmd.apply_packet && pkt_valid) begin
         last_in  = req_ff.sequence_number;
         cnt_in   = cnt_base;
         tot_in   = tot_base;
         if (cnt_base != COUNT_MAX) begin
            cnt_in = cnt_base + COUNT_WIDTH'(1);
            tot_in = tot_base + {(TOTAL_WIDTH - RSSI_WIDTH)'(0), req_ff.rssi_magnitude};
         end
         first_in = (first_base == '0) ? req_ff.sequence_number : first_base;
      end

      if (cmd.check) begin
         span_in = span_now;
      end

      if (cmd.take_rate) begin
         rate_q_in = div_quo;
      end

      if (cmd.emit) begin
         if (sweep_en_ff) begin
            best_pat_in  = better ? cur_pat_ff : best_pat_ff;
            best_err_in  = (cur_pat_ff == best_pat_in) ? rate_val : best_err_ff;
            cur_pat_in   = idx_now;
            sweep_idx_in = (idx_next >= PATTERN_LIMIT) ? '0 : idx_next[PATTERN_WIDTH-1:0];
         end
         rsp_in.batch_index    = batch_cnt_ff;
         rsp_in.batch_received = cnt_ff;
         rsp_in.batch_span     = span_ff;
         rsp_in.error_rate     = rate_val;
         rsp_in.rssi_average   = avg_val;
         rsp_in.pattern_used   = cur_pat_ff;
         rsp_in.best_pattern   = best_pat_in;
         rsp_in.next_pattern   = cur_pat_in;
         rsp_valid_in          = 1'b1;
      end

      if (cmd.emit || cmd.silent_close) begin
         batch_cnt_in = batch_cnt_ff + 32'd1;
         cnt_in       = '0;
         tot_in       = '0;
         first_in     = '0;
         last_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= BATCH_SIZE_RESET;
         sweep_en_ff  <= 1'b1;
         last_ff      <= '0;
         first_ff     <= '0;
         cnt_ff       <= '0;
         tot_ff       <= '0;
         batch_cnt_ff <= '0;
         cur_pat_ff   <= '0;
         sweep_idx_ff <= '0;
         best_pat_ff  <= '0;
         best_err_ff  <= BEST_ERROR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bs_ff        <= bs_in;
         sweep_en_ff  <= sweep_en_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
         cnt_ff       <= cnt_in;
         tot_ff       <= tot_in;
         batch_cnt_ff <= batch_cnt_in;
         cur_pat_ff   <= cur_pat_in;
         sweep_idx_ff <= sweep_idx_in;
         best_pat_ff  <= best_pat_in;
         best_err_ff  <= best_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      span_ff   <= span_in;
      rate_q_ff <= rate_q_in;
      rsp_ff    <= rsp_in;
   end

   assign status.close_needed = req_ff.mode
                                || (pkt_valid && span_now >= {16'd0, bs_ff});
   assign status.counter_zero = batch_cnt_ff == '0;
   assign status.div_busy     = div_busy;
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the batch packet error monitor, with an in-bench model of its summaries.
// Drives requests, timeouts and register writes, and compares every summary field by field.
// Depends on bpem_pkg and batch_packet_error_monitor_unit.
`timescale 1ns / 1ps

module tb_top;
   import bpem_pkg::*;

   localparam logic MODE_PACKET  = 1'b0;
   localparam logic MODE_TIMEOUT = 1'b1;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned PHASE_ITEMS     = 230;
   localparam int unsigned CLOSE_ALL_ITEMS = 250;
   localparam int unsigned DRAIN_CYCLES    = 60;

   class summary_tracker;
      logic [15:0] span_limit;
      logic        sweep_on;
      logic [31:0] last_seq;
      logic [31:0] first_seq;
      logic [31:0] batch_num;
      logic [15:0] rcv_count;
      logic [23:0] rssi_sum;
      logic [11:0] cur_pat;
      logic [11:0] best_pat;
      logic [16:0] best_err;
      int unsigned sweep_idx;
      rsp_type     pending_summaries[$];
      int unsigned failures;

      function new();
         span_limit = BATCH_SIZE_RESET;
         sweep_on   = 1'b1;
         last_seq   = '0;
         first_seq  = '0;
         batch_num  = '0;
         rcv_count  = '0;
         rssi_sum   = '0;
         cur_pat    = '0;
         best_pat   = '0;
         best_err   = BEST_ERROR_RESET;
         sweep_idx  = 0;
         failures   = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] data);
         if (index == CSR_BATCH_SIZE) begin
            span_limit = data;
         end else if (index == CSR_SWEEP_ENABLE) begin
            sweep_on = data[0];
         end
      endfunction

      function void close_batch();
         logic [31:0] span;
         logic [16:0] rate;
         logic [14:0] avg;
         logic [11:0] used;
         logic [63:0] num;
         logic [63:0] den;
         rsp_type     s;
         span = last_seq - first_seq + 32'd1;
         if (batch_num != 0) begin
            used = cur_pat;
            if (rcv_count == 0 || span == 0) begin
               rate = RATE_ONE;
               avg  = '0;
            end else begin
               if (32'(rcv_count) > span) begin
                  rate = '0;
               end else begin
                  num  = {16'd0, span - 32'(rcv_count), 16'd0};
                  den  = {32'd0, span};
                  rate = 17'(num / den);
               end
               num = {32'd0, rssi_sum, 8'd0};
               den = {48'd0, rcv_count};
               avg = 15'(num / den);
            end
            if (sweep_on) begin
               if (rate < best_err) begin
                  best_pat = cur_pat;
                  best_err = rate;
               end
               if (cur_pat == best_pat) begin
                  best_err = rate;
               end
               if (sweep_idx >= PATTERN_COUNT) begin
                  sweep_idx = 0;
               end
               cur_pat   = 12'(sweep_idx);
               sweep_idx = sweep_idx + 1;
               if (sweep_idx >= PATTERN_COUNT) begin
                  sweep_idx = 0;
               end
            end
            s.batch_index    = batch_num;
            s.batch_received = rcv_count;
            s.batch_span     = span;
            s.error_rate     = rate;
            s.rssi_average   = avg;
            s.pattern_used   = used;
            s.best_pattern   = best_pat;
            s.next_pattern   = cur_pat;
            pending_summaries.push_back(s);
         end
         batch_num = batch_num + 32'd1;
         rcv_count = '0;
         rssi_sum  = '0;
         first_seq = '0;
         last_seq  = '0;
      endfunction

      function void note_request(req_type r);
         if (r.mode == MODE_TIMEOUT) begin
            close_batch();
            return;
         end
         if (r.sequence_number == 0 || r.sequence_number == SEQ_ALL_ONES) begin
            return;
         end
         if (r.sequence_number < last_seq) begin
            rcv_count = '0;
            rssi_sum  = '0;
            first_seq = '0;
         end
         last_seq = r.sequence_number;
         if (rcv_count != COUNT_MAX) begin
            rcv_count = rcv_count + 16'd1;
            rssi_sum  = rssi_sum + 24'(r.rssi_magnitude);
         end
         if (first_seq == 0) begin
            first_seq = r.sequence_number;
         end
         if (last_seq - first_seq + 32'd1 >= 32'(span_limit)) begin
            close_batch();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_summary(rsp_type got);
         rsp_type want;
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected summary, expected none, actual %p", $time, got);
            failures++;
            return;
         end
         want = pending_summaries.pop_front();
         compare_field("batch_index", want.batch_index, got.batch_index);
         compare_field("batch_received", 32'(want.batch_received), 32'(got.batch_received));
         compare_field("batch_span", want.batch_span, got.batch_span);
         compare_field("error_rate", 32'(want.error_rate), 32'(got.error_rate));
         compare_field("rssi_average", 32'(want.rssi_average), 32'(got.rssi_average));
         compare_field("pattern_used", 32'(want.pattern_used), 32'(got.pattern_used));
         compare_field("best_pattern", 32'(want.best_pattern), 32'(got.best_pattern));
         compare_field("next_pattern", 32'(want.next_pattern), 32'(got.next_pattern));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   summary_tracker tracker = new();
   int unsigned    sender_idle_pct;
   int unsigned    receiver_stall_pct;
   logic [31:0]    cursor;

   batch_packet_error_monitor_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_summary(rsp_payload);
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      tracker.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic mode, input logic [31:0] seq, input logic [6:0] rssi);
      req_type r;
      r.mode            = mode;
      r.sequence_number = seq;
      r.rssi_magnitude  = rssi;
      send_request(r);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_register(index, data);
      @(negedge clock);
   endtask

   task automatic drain_summaries();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_summaries.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic req_type random_request();
      int unsigned pick;
      req_type     r;
      pick             = $urandom_range(0, 99);
      r.mode           = MODE_PACKET;
      r.rssi_magnitude = 7'($urandom);
      if (pick < 8) begin
         r.mode = MODE_TIMEOUT;
         cursor = $urandom;
      end else if (pick < 13) begin
         r.sequence_number = $urandom_range(0, 1) ? SEQ_ALL_ONES : '0;
         return r;
      end else if (pick < 20) begin
         cursor = (cursor > 32'd1) ? $urandom_range(1, cursor - 32'd1) : 32'd1;
      end else if (pick < 24) begin
         cursor = $urandom;
      end else if (pick < 32) begin
         cursor = cursor + $urandom_range(1, 70000);
      end else begin
         cursor = cursor + $urandom_range(0, 3);
      end
      r.sequence_number = cursor;
      return r;
   endfunction

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [15:0] sizes [RANDOM_PHASES];
      logic        sweeps [RANDOM_PHASES];
      sizes              = '{16'd100, 16'd1, 16'd0, 16'd65535, 16'd7, 16'd30};
      sweeps             = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_payload        = '0;
      rsp_stall          = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      sender_idle_pct    = 25;
      receiver_stall_pct = 52;
      cursor             = 32'd1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_fields(MODE_TIMEOUT, 32'd0, 7'd0);
      send_fields(MODE_PACKET, 32'd1, 7'd127);
      send_fields(MODE_PACKET, 32'd2, 7'd0);
      send_fields(MODE_PACKET, 32'd0, 7'd55);
      send_fields(MODE_PACKET, SEQ_ALL_ONES, 7'd99);
      send_fields(MODE_PACKET, 32'd5, 7'd64);
      send_fields(MODE_TIMEOUT, 32'd0, 7'd0);
      send_fields(MODE_TIMEOUT, SEQ_ALL_ONES, 7'd127);
      send_fields(MODE_PACKET, 32'd10, 7'd1);
      send_fields(MODE_PACKET, 32'd3, 7'd2);
      send_fields(MODE_PACKET, 32'd4, 7'd3);
      send_fields(MODE_TIMEOUT, 32'd123, 7'd0);
      send_fields(MODE_PACKET, 32'd1, 7'd20);
      send_fields(MODE_PACKET, 32'd100, 7'd40);
      repeat (3) send_fields(MODE_PACKET, 32'd7, 7'd127);
      send_fields(MODE_TIMEOUT, 32'd0, 7'd0);
      send_fields(MODE_PACKET, 32'd1, 7'd0);
      send_fields(MODE_PACKET, 32'hFFFF_FFFE, 7'd127);
      send_fields(MODE_PACKET, 32'hFFFF_FFFE, 7'd5);
      send_fields(MODE_TIMEOUT, 32'h5555_AAAA, 7'd42);
      drain_summaries();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 2) begin
            sender_idle_pct    = 25;
            receiver_stall_pct = 52;
         end else if (p < 4) begin
            sender_idle_pct    = 52;
            receiver_stall_pct = 25;
         end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         write_register(CSR_BATCH_SIZE, sizes[p]);
         write_register(CSR_SWEEP_ENABLE, {15'($urandom), sweeps[p]});
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_request(random_request());
         end
         drain_summaries();
      end

      // Every packet closes its batch here.
      write_register(CSR_BATCH_SIZE, 16'd0);
      write_register(CSR_SWEEP_ENABLE, 16'd1);
      for (int i = 0; i < CLOSE_ALL_ITEMS; i++) begin
         send_fields(MODE_PACKET, $urandom_range(1, 32'hFFFF_FFFE), 7'($urandom));
      end
      drain_summaries();

      if (tracker.failures == 0 && tracker.pending_summaries.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
